// File: rtl/packed_framebuffer_bitmap_blitter_macros.svh
// assertion macros for the packed framebuffer blitter checker
// expects clk and rst to be visible where a macro is used
`ifndef PACKED_FRAMEBUFFER_BITMAP_BLITTER_MACROS_SVH
`define PACKED_FRAMEBUFFER_BITMAP_BLITTER_MACROS_SVH

// same-cycle implication, off during reset
`define PFBB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define PFBB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pfbb_pkg.sv
// shared types, codes and defaults for the packed framebuffer blitter
// no dependencies
`timescale 1ns / 1ps

package pfbb_pkg;

  // parameter defaults
  localparam int SCREEN_WIDTH_DEF  = 320;
  localparam int SCREEN_HEIGHT_DEF = 240;
  localparam int FB_BPP_DEF        = 4;
  localparam int CMD_DEPTH_DEF     = 2;

  // command field widths
  localparam int REM_W       = 5;   // pixel slot in a word, up to 32 slots
  localparam int ADDR_MAX_W  = 18;  // word address at the largest screen
  localparam int SPAN_MAX    = 8;   // pixels one item can touch
  localparam int CFG_INDEX_W = 3;

  // operation codes
  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_INVERT = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_EXPAND = 2'd3;

  // source depth codes
  localparam logic [1:0] SRC_1BPP = 2'd0;
  localparam logic [1:0] SRC_2BPP = 2'd1;
  localparam logic [1:0] SRC_4BPP = 2'd2;
  localparam logic [1:0] SRC_8BPP = 2'd3;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_XOR_MODE        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TRANS_MODE      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FILL_BACKGROUND = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_LOW     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_HIGH    = 3'd4;

  typedef enum logic [1:0] {ACT_NONE, ACT_PAINT, ACT_INVERT} pix_act_t;
  typedef enum logic [1:0] {KIND_NOP, KIND_READ, KIND_WRITE} cmd_kind_t;

  // what to do with one pixel of the span, color already masked to depth
  typedef struct packed {
    pix_act_t   act;
    logic [7:0] color;
  } pix_op_t;

  // one classified command from the front end to the back end
  typedef struct packed {
    cmd_kind_t                kind;
    logic                     oor;
    logic [3:0]               span;
    logic [REM_W-1:0]         rem;
    logic [ADDR_MAX_W-1:0]    addr;
    pix_op_t [SPAN_MAX-1:0]   ops;
  } blt_cmd_t;

endpackage

// File: rtl/pfbb_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module pfbb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/pfbb_cmd_fifo.sv
// short command queue between front end and back end
// no dependencies
`timescale 1ns / 1ps

module pfbb_cmd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_FULL);
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

// File: rtl/pfbb_front.sv
// front end: configuration registers, item intake and classification
// depends on pfbb_pkg
`timescale 1ns / 1ps

module pfbb_front import pfbb_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int FB_BPP        = FB_BPP_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             opcode,
  input  logic [9:0]             x_pos,
  input  logic [9:0]             y_pos,
  input  logic [7:0]             color,
  input  logic [7:0]             src_byte,
  input  logic [1:0]             src_depth,
  input  logic [2:0]             first_pixel,
  input  logic [3:0]             pixel_count,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]            cfg_data,
  input  logic                   clearing,
  input  logic                   fifo_full,
  output logic                   push,
  output blt_cmd_t               push_cmd
);

  localparam int PPW         = 32 / FB_BPP;
  localparam int WPR         = (SCREEN_WIDTH + PPW - 1) / PPW;
  localparam int STORE_WORDS = WPR * SCREEN_HEIGHT;
  localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int QS          = 24;
  localparam logic [QS:0] RECIP = (QS + 1)'(((1 << QS) + PPW - 1) / PPW);
  localparam logic [10:0] SW = 11'(SCREEN_WIDTH);
  localparam logic [10:0] SH = 11'(SCREEN_HEIGHT);
  localparam logic [7:0] PIX_MASK8 = 8'((1 << FB_BPP) - 1);

  // configuration registers
  logic        xor_mode;
  logic        trans_mode;
  logic        fill_background;
  logic [63:0] palette_low;
  logic [63:0] palette_high;

  // intake stage registers
  logic                    f1_valid;
  cmd_kind_t               f1_kind;
  logic                    f1_oor;
  logic [3:0]              f1_span;
  pix_op_t [SPAN_MAX-1:0]  f1_ops;
  logic [9:0]              f1_x;
  logic [9:0]              f1_y;
  logic [9:0]              f1_q;

  // classification of the item on the input ports
  cmd_kind_t               c_kind;
  logic                    c_oor;
  logic [3:0]              c_span;
  pix_op_t [SPAN_MAX-1:0]  c_ops;
  logic [QS+10:0]          quo_prod;
  logic                    accept;

  // second stage address arithmetic
  logic [9:0]    rem10;
  logic [AW-1:0] addr_aw;

  function automatic logic [7:0] pal_entry(input logic [63:0] lo, input logic [63:0] hi,
                                           input logic [3:0] i);
    logic [63:0] bank;
    bank = i[3] ? hi : lo;
    return bank[{i[2:0], 3'b000} +: 8];
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = clearing || (f1_valid && fifo_full);
  assign accept    = in_valid && !in_stall;
  assign push      = f1_valid && !fifo_full;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      xor_mode        <= 1'b0;
      trans_mode      <= 1'b0;
      fill_background <= 1'b1;
      palette_low     <= '0;
      palette_high    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_XOR_MODE:        xor_mode        <= cfg_data[0];
        REG_TRANS_MODE:      trans_mode      <= cfg_data[0];
        REG_FILL_BACKGROUND: fill_background <= cfg_data[0];
        REG_PALETTE_LOW:     palette_low     <= cfg_data;
        REG_PALETTE_HIGH:    palette_high    <= cfg_data;
        default: ;
      endcase
    end
  end

  // classify the item: kind, range flag, span length and per-pixel actions
  always_comb begin
    logic       on_xy;
    logic [3:0] per_byte;
    logic [2:0] first_eff;
    logic [3:0] avail;
    logic [3:0] cnt;
    logic [10:0] room;
    logic [2:0] k;
    logic [5:0] sh;
    logic [7:0] sb;
    logic [7:0] idx8;
    on_xy     = ({1'b0, x_pos} < SW) && ({1'b0, y_pos} < SH);
    per_byte  = 4'd8 >> src_depth;
    first_eff = first_pixel & 3'(per_byte - 4'd1);
    avail     = per_byte - {1'b0, first_eff};
    cnt       = (pixel_count > avail) ? avail : pixel_count;
    room      = SW - {1'b0, x_pos};
    c_kind    = KIND_NOP;
    c_oor     = 1'b0;
    c_span    = '0;
    c_ops     = '0;
    case (opcode)
      OP_SET, OP_INVERT, OP_READ: begin
        if (!on_xy) begin
          c_oor = 1'b1;
        end else begin
          c_kind = (opcode == OP_READ) ? KIND_READ : KIND_WRITE;
          c_span = 4'd1;
        end
        c_ops[0].act   = (opcode == OP_SET) ? ACT_PAINT : ACT_INVERT;
        c_ops[0].color = color & PIX_MASK8;
      end
      OP_EXPAND: begin
        if (cnt != 4'd0) begin
          if (!on_xy) begin
            c_oor = 1'b1;
          end else begin
            c_kind = KIND_WRITE;
            if ({7'b0, cnt} > room) begin
              c_oor  = 1'b1;
              c_span = room[3:0];
            end else begin
              c_span = cnt;
            end
          end
        end
        // one action per source pixel of the span
        for (int j = 0; j < SPAN_MAX; j++) begin
          k  = first_eff + 3'(j);
          sh = {3'b000, k} << src_depth;
          sb = src_byte << sh;
          case (src_depth)
            SRC_1BPP: idx8 = {7'b0, sb[7]};
            SRC_2BPP: idx8 = {6'b0, sb[7:6]};
            SRC_4BPP: idx8 = {4'b0, sb[7:4]};
            default:  idx8 = sb;
          endcase
          c_ops[j].act   = ACT_NONE;
          c_ops[j].color = '0;
          if (src_depth == SRC_1BPP) begin
            if (idx8 != 8'd0) begin
              if (xor_mode) begin
                c_ops[j].act = ACT_INVERT;
              end else begin
                c_ops[j].act   = ACT_PAINT;
                c_ops[j].color = pal_entry(palette_low, palette_high, 4'd1) & PIX_MASK8;
              end
            end else if (!xor_mode && fill_background) begin
              c_ops[j].act   = ACT_PAINT;
              c_ops[j].color = pal_entry(palette_low, palette_high, 4'd0) & PIX_MASK8;
            end
          end else if (!(trans_mode && idx8 == 8'd0)) begin
            c_ops[j].act = ACT_PAINT;
            if (src_depth == SRC_8BPP) begin
              c_ops[j].color = idx8 & PIX_MASK8;
            end else begin
              c_ops[j].color = pal_entry(palette_low, palette_high, idx8[3:0]) & PIX_MASK8;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // column over pixels-per-word by reciprocal multiply
  assign quo_prod = (QS + 11)'(x_pos) * (QS + 11)'(RECIP);

  // intake stage
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (accept) begin
      f1_valid <= 1'b1;
    end else if (push) begin
      f1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_kind <= c_kind;
      f1_oor  <= c_oor;
      f1_span <= c_span;
      f1_ops  <= c_ops;
      f1_x    <= x_pos;
      f1_y    <= y_pos;
      f1_q    <= quo_prod[QS +: 10];
    end
  end

  // word address and pixel slot, then pack the command
  always_comb begin
    rem10   = f1_x - 10'(f1_q * PPW);
    addr_aw = AW'(f1_y * WPR) + AW'(f1_q);
    push_cmd.kind = f1_kind;
    push_cmd.oor  = f1_oor;
    push_cmd.span = f1_span;
    push_cmd.rem  = rem10[REM_W-1:0];
    push_cmd.addr = ADDR_MAX_W'(addr_aw);
    push_cmd.ops  = f1_ops;
  end

endmodule

// File: rtl/pfbb_back.sv
// back end: store clearing, word read-modify-write and result register
// depends on pfbb_pkg and pfbb_ram
`timescale 1ns / 1ps

module pfbb_back import pfbb_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int FB_BPP        = FB_BPP_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fifo_empty,
  input  blt_cmd_t   head_cmd,
  output logic       pop,
  output logic       clearing,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_value,
  output logic       out_of_range
);

  localparam int PPW         = 32 / FB_BPP;
  localparam int WPR         = (SCREEN_WIDTH + PPW - 1) / PPW;
  localparam int STORE_WORDS = WPR * SCREEN_HEIGHT;
  localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int LIW         = $clog2(PPW);
  localparam logic [AW-1:0] CLR_LAST = AW'(STORE_WORDS - 1);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_MOD, S_DONE} state_t;

  state_t                  state;
  logic [AW-1:0]           clr_cnt;

  // current command
  cmd_kind_t               w_kind;
  logic [3:0]              w_span;
  logic [REM_W-1:0]        w_rem;
  logic [AW-1:0]           w_addr;
  logic [6:0]              w_jbase;
  pix_op_t [SPAN_MAX-1:0]  w_ops;
  logic [7:0]              res_rd;
  logic                    res_oor;

  // store port
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [AW-1:0] raddr;
  logic [31:0]   rd_data;

  // lane logic
  logic [FB_BPP-1:0] lane_old [PPW];
  logic [31:0]       new_word;
  logic [6:0]        jnext;
  logic              more;

  assign clearing = (state == S_CLEAR);
  assign pop      = (state == S_IDLE) && !fifo_empty;

  // next span offset and whether the span runs into the next word
  assign jnext = w_jbase + 7'(PPW);
  assign more  = !jnext[6] && (jnext[5:0] < {2'b00, w_span});

  // per-pixel merge of the word just read
  always_comb begin
    logic [6:0]        j;
    logic              in_span;
    pix_op_t           op;
    logic [FB_BPP-1:0] lane_new;
    new_word = rd_data;
    for (int p = 0; p < PPW; p++) begin
      j           = w_jbase + 7'(p);
      lane_old[p] = rd_data[31 - FB_BPP * p -: FB_BPP];
      in_span     = !j[6] && (j[5:0] < {2'b00, w_span});
      op          = w_ops[j[2:0]];
      lane_new    = lane_old[p];
      if (in_span && op.act == ACT_PAINT) begin
        lane_new = op.color[FB_BPP-1:0];
      end else if (in_span && op.act == ACT_INVERT) begin
        lane_new = ~lane_old[p];
      end
      new_word[31 - FB_BPP * p -: FB_BPP] = lane_new;
    end
  end

  // store port control
  always_comb begin
    we    = 1'b0;
    waddr = w_addr;
    wdata = new_word;
    raddr = w_addr + 1'b1;
    case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt;
        wdata = '0;
      end
      S_IDLE: begin
        raddr = head_cmd.addr[AW-1:0];
      end
      S_MOD: begin
        we = (w_kind == KIND_WRITE);
      end
      default: ;
    endcase
  end

  pfbb_ram #(
    .WIDTH (32),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // sequencer, working registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      // result taken and nothing new to load this cycle
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CLR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!fifo_empty) begin
            w_kind  <= head_cmd.kind;
            w_span  <= head_cmd.span;
            w_rem   <= head_cmd.rem;
            w_addr  <= head_cmd.addr[AW-1:0];
            w_jbase <= -(7'(head_cmd.rem));
            w_ops   <= head_cmd.ops;
            res_rd  <= '0;
            res_oor <= head_cmd.oor;
            state   <= (head_cmd.kind == KIND_NOP) ? S_DONE : S_MOD;
          end
        end
        S_MOD: begin
          if (w_kind == KIND_READ) begin
            res_rd <= 8'(lane_old[w_rem[LIW-1:0]]);
            state  <= S_DONE;
          end else if (more) begin
            w_addr  <= w_addr + 1'b1;
            w_jbase <= jnext;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            read_value   <= res_rd;
            out_of_range <= res_oor;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/packed_framebuffer_bitmap_blitter.sv
// top level of the packed framebuffer blitter: front end, command queue, back end
// depends on pfbb_pkg, pfbb_front, pfbb_cmd_fifo, pfbb_back
//
// channel  direction  handshake             payload
// in       to block   in_valid / in_stall   opcode x_pos y_pos color src_byte
//                                           src_depth first_pixel pixel_count
// out      from block out_valid / out_stall read_value out_of_range
// cfg      to block   cfg_valid / cfg_ready cfg_index cfg_data
//
// the back end takes an item in S_IDLE, spends S_MOD on each store word its span covers
// (a read-modify-write on the store's one write port), then S_DONE; an item that misses
// the store goes from S_IDLE straight to S_DONE.
// the front end registers each item in its intake stage and keeps taking items until the 2-deep queue fills.
// after reset the store is cleared one word a cycle, all STORE_WORDS words (9600 at the
// default size), with in_stall high; cfg writes are taken throughout.
// a stalled result waits in the output register while the back end works on one more.
`timescale 1ns / 1ps

module packed_framebuffer_bitmap_blitter import pfbb_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int FB_BPP        = FB_BPP_DEF,
  parameter int CMD_DEPTH     = CMD_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             opcode,
  input  logic [9:0]             x_pos,
  input  logic [9:0]             y_pos,
  input  logic [7:0]             color,
  input  logic [7:0]             src_byte,
  input  logic [1:0]             src_depth,
  input  logic [2:0]             first_pixel,
  input  logic [3:0]             pixel_count,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             read_value,
  output logic                   out_of_range,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]            cfg_data
);

  logic     clearing;
  logic     fifo_full;
  logic     fifo_empty;
  logic     push;
  logic     pop;
  blt_cmd_t push_cmd;
  blt_cmd_t head_cmd;

  pfbb_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .FB_BPP        (FB_BPP)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .x_pos       (x_pos),
    .y_pos       (y_pos),
    .color       (color),
    .src_byte    (src_byte),
    .src_depth   (src_depth),
    .first_pixel (first_pixel),
    .pixel_count (pixel_count),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .clearing    (clearing),
    .fifo_full   (fifo_full),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  pfbb_cmd_fifo #(
    .WIDTH ($bits(blt_cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_cmd),
    .pop   (pop),
    .rdata (head_cmd),
    .full  (fifo_full),
    .empty (fifo_empty)
  );

  pfbb_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .FB_BPP        (FB_BPP)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .fifo_empty   (fifo_empty),
    .head_cmd     (head_cmd),
    .pop          (pop),
    .clearing     (clearing),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .read_value   (read_value),
    .out_of_range (out_of_range)
  );

endmodule

// File: rtl/pfbb_checker.sv
// port-level checks for the packed framebuffer blitter, bound to the top level
// depends on pfbb_pkg and packed_framebuffer_bitmap_blitter_macros.svh
`timescale 1ns / 1ps
`include "packed_framebuffer_bitmap_blitter_macros.svh"

module pfbb_checker import pfbb_pkg::*; #(
  parameter int FB_BPP = FB_BPP_DEF
) (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] read_value,
  input logic       out_of_range,
  input logic       cfg_valid,
  input logic       cfg_ready
);

  // a held result keeps its payload
  `PFBB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(read_value) && $stable(out_of_range), "result changed while stalled")

  // the store clear runs right after reset, so no item is taken then
  `PFBB_ASSERT_NOW(a_clear_after_reset, $past(rst), in_stall, "item taken before store clear")

  // a pixel read never carries bits above the framebuffer depth
  `PFBB_ASSERT_NOW(a_read_depth, out_valid, (read_value >> FB_BPP) == 8'd0, "read value wider than pixel")

  // an out-of-range transaction never reports a pixel
  `PFBB_ASSERT_NOW(a_oor_zero, out_valid && out_of_range, read_value == 8'd0, "off-screen result with data")

  // configuration writes never wait
  `PFBB_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "cfg write refused")

endmodule

bind packed_framebuffer_bitmap_blitter pfbb_checker #(
  .FB_BPP (FB_BPP)
) u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .read_value   (read_value),
  .out_of_range (out_of_range),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready)
);
